// ===== sv/bsr_pkg.sv =====
// Shared types and constants for the byte stream reassembler.
package bsr_pkg;

    localparam int WINDOW_DEF = 64;
    localparam int IDX_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int PEND_W     = 7;

    typedef struct packed {
        logic [IDX_W-1:0]  stream_index;
        logic [BYTE_W-1:0] in_byte;
        logic              has_byte;
        logic              end_mark;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              last_of_run;
        logic              stream_done;
        logic [PEND_W-1:0] pending_count;
        logic              dropped;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } t_state;

endpackage

// ===== sv/bsr_slot_ram.sv =====
// Byte slot memory: one write port, one registered read port with enable.
module bsr_slot_ram
    import bsr_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int AW     = $clog2(WINDOW)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [WINDOW];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/byte_stream_reassembler_unit.sv =====
// Byte stream reassembler top level: slot ring, delivery sequencer, output register.
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid / o_in_stall  | i_in_beat  (t_in_beat)
//   out     | output    | o_out_valid / i_out_stall | o_out_beat (t_out_beat)
// An item is stored in the idle step, then each delivered byte takes a valid check
// and memory read, then an output load; an item that delivers nothing still passes both.
// The registered read port of the byte memory splits each byte into a read and a load step.
// Synchronous active-low reset clears the valid bits, the pointers and the end record.
// A stalled output holds the sequencer in its load step; input is taken only when idle.
module byte_stream_reassembler_unit
    import bsr_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW:0]      WIN_SUM = (AW+1)'(WINDOW);
    localparam logic [AW-1:0]    WIN_TOP = AW'(WINDOW - 1);
    localparam logic [IDX_W-1:0] WIN_IDX = IDX_W'(WINDOW);

    t_state r_state, n_state;

    logic [IDX_W-1:0]  r_next, n_next;
    logic [AW-1:0]     r_head, n_head;
    logic [WINDOW-1:0] r_valid, n_valid;
    logic [IDX_W:0]    r_end, n_end;
    logic              r_end_known, n_end_known;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic              r_drop, n_drop;
    logic              r_empty, n_empty;
    logic              r_ovalid, n_ovalid;
    t_out_beat         r_obeat, n_obeat;

    logic              accept;
    logic              out_free;
    logic [IDX_W-1:0]  offset;
    logic [AW:0]       slot_sum;
    logic [AW-1:0]     slot;
    logic              in_window;
    logic              store;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_ovalid || !i_out_stall;

    assign offset    = i_in_beat.stream_index - r_next;
    assign in_window = (i_in_beat.stream_index >= r_next) && (offset < WIN_IDX);
    assign slot_sum  = {1'b0, r_head} + {1'b0, offset[AW-1:0]};
    assign slot      = (slot_sum >= WIN_SUM) ? AW'(slot_sum - WIN_SUM) : slot_sum[AW-1:0];
    assign store     = accept && i_in_beat.has_byte && in_window && !r_valid[slot];
    assign ram_re    = (r_state == ST_CHECK) && r_valid[r_head];

    bsr_slot_ram #(
        .WINDOW (WINDOW),
        .AW     (AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (slot),
        .i_wdata (i_in_beat.in_byte),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_empty || !r_valid[r_head]) ? ST_IDLE : ST_CHECK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_next      = r_next;
        n_head      = r_head;
        n_valid     = r_valid;
        n_end       = r_end;
        n_end_known = r_end_known;
        n_pend      = r_pend;
        n_drop      = r_drop;
        n_empty     = r_empty;
        n_ovalid    = r_ovalid;
        n_obeat     = r_obeat;
        if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_drop = i_in_beat.has_byte && (i_in_beat.stream_index >= r_next)
                             && !in_window;
                    if (store) begin
                        n_valid[slot] = 1'b1;
                        n_pend        = r_pend + 1'b1;
                    end
                    if (i_in_beat.end_mark) begin
                        n_end       = {1'b0, i_in_beat.stream_index}
                                      + {{IDX_W{1'b0}}, i_in_beat.has_byte};
                        n_end_known = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                n_empty = !r_valid[r_head];
                if (r_valid[r_head]) begin
                    n_valid[r_head] = 1'b0;
                    n_pend          = r_pend - 1'b1;
                    n_next          = r_next + 1'b1;
                    if (r_next == {IDX_W{1'b1}} || r_head == WIN_TOP) begin
                        n_head = '0;
                    end else begin
                        n_head = r_head + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ovalid              = 1'b1;
                    n_obeat.out_byte      = r_empty ? '0 : ram_rdata;
                    n_obeat.out_valid     = !r_empty;
                    n_obeat.last_of_run   = r_empty || !r_valid[r_head];
                    n_obeat.stream_done   = r_end_known && (r_end == {1'b0, r_next});
                    n_obeat.pending_count = r_pend;
                    n_obeat.dropped       = r_drop;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next      <= '0;
            r_head      <= '0;
            r_valid     <= '0;
            r_end       <= '0;
            r_end_known <= 1'b0;
            r_pend      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_head      <= n_head;
            r_valid     <= n_valid;
            r_end       <= n_end;
            r_end_known <= n_end_known;
            r_pend      <= n_pend;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_drop  <= n_drop;
        r_empty <= n_empty;
        r_obeat <= n_obeat;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_obeat;

endmodule
